FILE: rtl/core/hash_table_store_probe_with_replacement_assert.svh
// assertion macros for the hash table store/probe block
`ifndef HASH_TABLE_STORE_PROBE_WITH_REPLACEMENT_ASSERT_SVH
`define HASH_TABLE_STORE_PROBE_WITH_REPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define HTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hts assertion failed");

// next-cycle implication, disabled while in reset
`define HTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hts assertion failed");

`else

`define HTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/hts_pkg.sv
// shared types and constants of the hash table store/probe block
package hts_pkg;

    // action codes
    localparam logic ACTION_PROBE = 1'b0;
    localparam logic ACTION_STORE = 1'b1;

    // bound flag codes
    localparam logic [1:0] FLAG_EXACT = 2'd0;

    // write outcome codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    // replacement margin terms
    localparam int DEPTH_BONUS = 7;
    localparam int PV_BONUS    = 2;
    localparam int DEPTH_SLACK = 4;

    // width of the replacement compare
    localparam int CMP_W = 10;

    // slot contents apart from the tag
    typedef struct packed {
        logic [7:0]         age;
        logic signed [15:0] eval;
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [1:0]         flag;
        logic [15:0]        move;
    } slot_body_t;

    localparam int SLOT_BODY_W = $bits(slot_body_t);

    // request fields apart from the key
    typedef struct packed {
        logic               action;
        logic [1:0]         flag;
        logic [15:0]        move;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic signed [15:0] eval;
        logic               pv;
    } req_t;

    // result item
    typedef struct packed {
        logic               hit;
        logic [1:0]         kind;
        logic [15:0]        move;
        logic [1:0]         flag;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic signed [15:0] eval;
    } result_t;

endpackage

FILE: rtl/core/hts_slot_ram.sv
// slot memory: one write port, one registered read port
module hts_slot_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 82
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered on rd_en
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/hts_update.sv
// replacement decision and slot update for one request
module hts_update #(
    parameter int KEY_BITS = 16
) (
    input  hts_pkg::req_t       req,
    input  logic [KEY_BITS-1:0] req_tag,
    input  logic [7:0]          current_age,
    input  logic [KEY_BITS-1:0] old_tag,
    input  hts_pkg::slot_body_t old_body,
    output logic                wr_en,
    output logic [KEY_BITS-1:0] new_tag,
    output hts_pkg::slot_body_t new_body,
    output hts_pkg::result_t    res
);

    import hts_pkg::*;

    logic             hit;
    logic             may_replace;
    logic             deeper;
    logic             full_wr;
    logic             move_wr;
    logic [CMP_W-1:0] lhs;
    logic [CMP_W-1:0] rhs;

    // tag match and replacement permission
    assign hit         = (old_tag == req_tag);
    assign may_replace = (old_tag == '0) || (old_body.age != current_age) ||
                         (old_body.depth <= req.depth);

    // depth + 7 + 2*pv > old_depth - 4, moved so both sides stay non-negative
    assign lhs = CMP_W'(req.depth) + CMP_W'(DEPTH_BONUS) + CMP_W'(DEPTH_SLACK) +
                 (req.pv ? CMP_W'(PV_BONUS) : '0);
    assign rhs    = CMP_W'(old_body.depth);
    assign deeper = (lhs > rhs);

    // outcome of the store
    assign full_wr = (req.action == ACTION_STORE) && may_replace &&
                     ((req.flag == FLAG_EXACT) || !hit || deeper);
    assign move_wr = (req.action == ACTION_STORE) && may_replace && !full_wr &&
                     (req.move != '0);
    assign wr_en   = full_wr || move_wr;

    // new slot contents
    always_comb begin
        new_tag  = old_tag;
        new_body = old_body;
        if (full_wr) begin
            new_tag        = req_tag;
            new_body.age   = current_age;
            new_body.eval  = req.eval;
            new_body.score = req.score;
            new_body.depth = req.depth;
            new_body.flag  = req.flag;
            new_body.move  = req.move;
        end else if (move_wr) begin
            new_body.move = req.move;
        end
    end

    // result item
    always_comb begin
        res.hit   = hit;
        res.kind  = full_wr ? KIND_FULL : (move_wr ? KIND_MOVE : KIND_NONE);
        res.move  = ((req.action == ACTION_PROBE) && !hit) ? '0 : new_body.move;
        res.flag  = new_body.flag;
        res.depth = new_body.depth;
        res.score = new_body.score;
        res.eval  = new_body.eval;
    end

endmodule

FILE: rtl/core/hash_table_store_probe_with_replacement.sv
// top level of the hash table store/probe block with depth/age replacement
// Direct-mapped table of 2**INDEX_BITS slots held in one synchronous memory. The slot
// index is the top INDEX_BITS bits of the 64-bit key and the tag its low KEY_BITS bits.
// After reset a clearing pass writes zero to every slot, one slot per cycle; s_tready
// stays low until it finishes, while current_age writes are taken as usual. For each
// item the accept cycle launches the slot read, and the modify state decides the
// replacement, writes the slot back and loads the result register. The next item is
// accepted only after that write, so same-slot requests always see the updated slot. A
// result waiting in the output register does not block the next item; it stalls only the
// write-back.
module hash_table_store_probe_with_replacement #(
    parameter int INDEX_BITS = 16,
    parameter int KEY_BITS   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,  // current_age
    // request items
    input  logic         s_tvalid,
    output logic         s_tready,
    // hash_key[63:0], bound_flag[65:64], best_move[81:66], search_depth[89:82],
    // search_score[105:90], static_eval[121:106], is_pv[122], zero[127:123]
    input  logic [127:0] s_tdata,
    input  logic         s_tuser,      // action[0]
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_move[15:0], entry_flag[17:16], entry_depth[25:18], entry_score[41:26],
    // entry_eval[57:42], zero[63:58]
    output logic [63:0]  m_tdata,
    output logic [2:0]   m_tuser       // hit[0], write_kind[2:1]
);

    import hts_pkg::*;

    `include "hash_table_store_probe_with_replacement_assert.svh"

    localparam int DATA_W = KEY_BITS + SLOT_BODY_W;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_MODIFY = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_idx_reg, clr_idx_next;
    logic [7:0]            age_reg, age_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_res_reg, out_res_next;
    req_t                  req_reg, req_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [KEY_BITS-1:0]   tag_reg, tag_next;

    logic                  accept;
    logic                  commit;
    logic [INDEX_BITS-1:0] in_idx;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;
    logic [DATA_W-1:0]     mem_wdata;
    logic [DATA_W-1:0]     mem_rdata;
    logic [KEY_BITS-1:0]   old_tag;
    slot_body_t            old_body;
    logic                  upd_we;
    logic [KEY_BITS-1:0]   new_tag;
    slot_body_t            new_body;
    result_t               upd_res;

    // handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_MODIFY) && (!out_valid_reg || m_tready);
    assign in_idx   = s_tdata[63 -: INDEX_BITS];

    // request capture
    always_comb begin
        req_next = req_reg;
        idx_next = idx_reg;
        tag_next = tag_reg;
        if (accept) begin
            req_next.action = s_tuser;
            req_next.flag   = s_tdata[65:64];
            req_next.move   = s_tdata[81:66];
            req_next.depth  = s_tdata[89:82];
            req_next.score  = s_tdata[105:90];
            req_next.eval   = s_tdata[121:106];
            req_next.pv     = s_tdata[122];
            idx_next        = in_idx;
            tag_next        = s_tdata[KEY_BITS-1:0];
        end
    end

    // control: clearing pass, idle, modify
    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // age register
    assign age_next = cfg_wr_en ? cfg_wr_data : age_reg;

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (commit) begin
            out_valid_next = 1'b1;
            out_res_next   = upd_res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            age_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            age_reg       <= age_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        tag_reg     <= tag_next;
    end

    // memory write port: clearing pass or write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {new_tag, new_body};
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end else if (commit) begin
            mem_we = upd_we;
        end
    end

    hts_slot_ram #(
        .ADDR_W (INDEX_BITS),
        .DATA_W (DATA_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (mem_rdata)
    );

    assign old_tag  = mem_rdata[DATA_W-1 -: KEY_BITS];
    assign old_body = slot_body_t'(mem_rdata[SLOT_BODY_W-1:0]);

    hts_update #(
        .KEY_BITS (KEY_BITS)
    ) u_update (
        .req         (req_reg),
        .req_tag     (tag_reg),
        .current_age (age_reg),
        .old_tag     (old_tag),
        .old_body    (old_body),
        .wr_en       (upd_we),
        .new_tag     (new_tag),
        .new_body    (new_body),
        .res         (upd_res)
    );

    // result ports
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_res_reg.eval, out_res_reg.score, out_res_reg.depth,
                       out_res_reg.flag, out_res_reg.move};
    assign m_tuser  = {out_res_reg.kind, out_res_reg.hit};

    // checks
    `HTS_ASSERT_NXT(a_accept_to_modify, aclk, aresetn, accept, state_reg == ST_MODIFY)
    `HTS_ASSERT_NXT(a_commit_gives_item, aclk, aresetn, commit, out_valid_reg && s_tready)
    `HTS_ASSERT_IMP(a_no_item_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !out_valid_reg)
    `HTS_ASSERT_IMP(a_write_only_store, aclk, aresetn, commit && upd_we, req_reg.action == ACTION_STORE)
    `HTS_ASSERT_NXT(a_kind_only_store, aclk, aresetn, commit && (upd_res.kind != KIND_NONE), $past(req_reg.action) == ACTION_STORE)

endmodule

FILE: verif/hash_table_store_probe_with_replacement_test.sv
// self-checking testbench for the hash table store/probe block with depth/age replacement
module hash_table_store_probe_with_replacement_test;
    import hts_pkg::*;

    // bound flag codes that the package leaves unnamed
    localparam logic [1:0] FLAG_LOWER = 2'd1;
    localparam logic [1:0] FLAG_UPPER = 2'd2;
    localparam logic [1:0] FLAG_THREE = 2'd3;

    localparam int ITEMS_PER_PHASE = 210;
    localparam int AGE_PHASES      = 5;

    typedef struct packed {
        logic               action;
        logic [63:0]        key;
        logic [1:0]         flag;
        logic [15:0]        move;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic signed [15:0] eval;
        logic               pv;
    } tt_request_t;

    typedef struct packed {
        logic [15:0] tag;
        slot_body_t  body;
    } mirror_slot_t;

    typedef struct {
        tt_request_t req;
        bit          fixed;
        result_t     want;
    } directed_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [7:0]   cfg_wr_data = 8'd0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = ACTION_PROBE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;

    // predictor state: slots touched so far, all others read as cleared
    mirror_slot_t  slot_mirror [int unsigned];
    logic [7:0]    age_now = 8'd0;
    result_t       expected_results [$];
    directed_row_t directed_rows [$];

    logic [15:0] hot_slots [6] = '{16'h0000, 16'h0001, 16'h5A5A, 16'hA5A5, 16'hFFFF, 16'h8000};
    logic [15:0] hot_tags [4]  = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF};
    logic [7:0]  phase_ages [AGE_PHASES] = '{8'd255, 8'd1, 8'd128, 8'd0, 8'd0};
    logic [63:0] last_key = '0;

    bit no_idle = 1'b0;
    int ready_wait = 0;
    int mismatch_count = 0;
    int probes_sent = 0, stores_sent = 0;
    int hits_seen = 0, full_seen = 0, move_seen = 0, none_seen = 0;

    hash_table_store_probe_with_replacement dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit
    initial begin
        #(12 * 2_000_000);
        $display("timeout waiting for the block");
        $display("[FAIL] regression broken");
        $finish;
    end

    // per-item wait in cycles, zero during no-idle stretches
    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 16));
    endfunction

    // slot lookup and replacement decision, updates the mirror
    function automatic result_t predict_slot_access(input tt_request_t q);
        mirror_slot_t s;
        logic [15:0]  idx;
        logic [15:0]  tag;
        int           lhs;
        int           rhs;
        result_t      r;
        idx = q.key[63:48];
        tag = q.key[15:0];
        s = slot_mirror.exists(idx) ? slot_mirror[idx] : '0;
        r = '0;
        r.hit = (s.tag == tag);
        r.kind = KIND_NONE;
        if (q.action == ACTION_STORE) begin
            if (s.tag == 16'h0 || s.body.age != age_now || s.body.depth <= q.depth) begin
                lhs = int'(q.depth) + DEPTH_BONUS + (q.pv ? PV_BONUS : 0);
                rhs = int'(s.body.depth) - DEPTH_SLACK;
                if (q.flag == FLAG_EXACT || !r.hit || lhs > rhs) begin
                    s.tag = tag;
                    s.body.flag = q.flag;
                    s.body.move = q.move;
                    s.body.depth = q.depth;
                    s.body.score = q.score;
                    s.body.eval = q.eval;
                    s.body.age = age_now;
                    r.kind = KIND_FULL;
                end else if (q.move != 16'h0) begin
                    s.body.move = q.move;
                    r.kind = KIND_MOVE;
                end
            end
            slot_mirror[idx] = s;
            r.move = s.body.move;
        end else begin
            r.move = r.hit ? s.body.move : 16'h0;
        end
        r.flag = s.body.flag;
        r.depth = s.body.depth;
        r.score = s.body.score;
        r.eval = s.body.eval;
        return r;
    endfunction

    function automatic void add_row(input logic act, input logic [15:0] idx,
                                    input logic [15:0] tag, input logic [1:0] flag,
                                    input logic [15:0] mv, input logic [7:0] dep,
                                    input logic [15:0] sc, input logic [15:0] ev,
                                    input logic pv, input bit fixed = 1'b0,
                                    input result_t want = '0);
        directed_row_t row;
        row.req = '{act, {idx, 32'($urandom), tag}, flag, mv, dep, sc, ev, pv};
        row.fixed = fixed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // random item, mostly on a few hot slots and tags so that entries collide
    function automatic tt_request_t random_request();
        tt_request_t q;
        logic [15:0] idx;
        logic [15:0] tag;
        q.action = ($urandom_range(0, 99) < 55) ? ACTION_STORE : ACTION_PROBE;
        if ($urandom_range(0, 9) < 3) begin
            q.key = last_key;
        end else begin
            idx = ($urandom_range(0, 4) != 0) ? hot_slots[$urandom_range(0, 5)] : 16'($urandom);
            tag = ($urandom_range(0, 9) < 7) ? hot_tags[$urandom_range(0, 3)] : 16'($urandom);
            q.key = {idx, 32'($urandom), tag};
        end
        last_key = q.key;
        q.flag = 2'($urandom_range(0, 3));
        q.move = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
        q.depth = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 40)) : 8'($urandom);
        q.score = 16'($urandom);
        q.eval = 16'($urandom);
        q.pv = 1'($urandom);
        return q;
    endfunction

    task automatic set_age(input logic [7:0] a);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        age_now = a;
    endtask

    // hold the sender until every expected result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_item(input tt_request_t q, input bit fixed, input result_t want);
        int      gap;
        result_t got;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= q.action;
        s_tdata <= {5'b0, q.pv, q.eval, q.score, q.depth, q.move, q.flag, q.key};
        do @(posedge aclk); while (s_tready !== 1'b1);
        got = predict_slot_access(q);
        expected_results.push_back(fixed ? want : got);
        if (q.action == ACTION_STORE) stores_sent++;
        else probes_sent++;
    endtask

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_wait = 0;
        end else if (m_tvalid && m_tready) begin
            ready_wait = draw_gap();
            m_tready <= (ready_wait == 0);
        end else if (!m_tready) begin
            if (ready_wait > 0) ready_wait--;
            m_tready <= (ready_wait == 0);
        end
    end

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result item, expected none, got %h/%h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("hit", 16'(want.hit), 16'(m_tuser[0]));
                check_field("write_kind", 16'(want.kind), 16'(m_tuser[2:1]));
                check_field("entry_move", want.move, m_tdata[15:0]);
                check_field("entry_flag", 16'(want.flag), 16'(m_tdata[17:16]));
                check_field("entry_depth", 16'(want.depth), 16'(m_tdata[25:18]));
                check_field("entry_score", want.score, m_tdata[41:26]);
                check_field("entry_eval", want.eval, m_tdata[57:42]);
            end
            if (m_tuser[0]) hits_seen++;
            case (m_tuser[2:1])
                KIND_FULL: full_seen++;
                KIND_MOVE: move_seen++;
                default:   none_seen++;
            endcase
        end
    end

    // directed rows at age 0, then random phases over several ages
    initial begin : stimulus
        int n;
        int ph;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        set_age(8'd0);

        // empty table: far miss, then a zero tag that hits the cleared slot
        add_row(ACTION_PROBE, 16'hFFFF, 16'hFFFF, FLAG_EXACT, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0,
                1'b1, '{1'b0, KIND_NONE, 16'h0, FLAG_EXACT, 8'h00, 16'sh0, 16'sh0});
        add_row(ACTION_PROBE, 16'h0000, 16'h0000, FLAG_EXACT, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0,
                1'b1, '{1'b1, KIND_NONE, 16'h0, FLAG_EXACT, 8'h00, 16'sh0, 16'sh0});
        // extreme store into an empty slot, then hit and miss probes
        add_row(ACTION_STORE, 16'h0000, 16'h0001, FLAG_EXACT, 16'hFFFF, 8'hFF, 16'h7FFF,
                16'h8000, 1'b1,
                1'b1, '{1'b0, KIND_FULL, 16'hFFFF, FLAG_EXACT, 8'hFF, 16'sh7FFF, 16'sh8000});
        add_row(ACTION_PROBE, 16'h0000, 16'h0001, FLAG_EXACT, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0,
                1'b1, '{1'b1, KIND_NONE, 16'hFFFF, FLAG_EXACT, 8'hFF, 16'sh7FFF, 16'sh8000});
        add_row(ACTION_PROBE, 16'h0000, 16'h0002, FLAG_LOWER, 16'h1, 8'h01, 16'h1, 16'h1, 1'b1,
                1'b1, '{1'b0, KIND_NONE, 16'h0, FLAG_EXACT, 8'hFF, 16'sh7FFF, 16'sh8000});
        // same age and shallower: refused
        add_row(ACTION_STORE, 16'h0000, 16'h0001, FLAG_LOWER, 16'h1234, 8'h00, 16'h0, 16'h0,
                1'b0,
                1'b1, '{1'b1, KIND_NONE, 16'hFFFF, FLAG_EXACT, 8'hFF, 16'sh7FFF, 16'sh8000});
        // tag mismatch into empty, then a deeper-margin overwrite on a hit
        add_row(ACTION_STORE, 16'h0001, 16'h0005, FLAG_LOWER, 16'h1111, 8'd20, 16'hFFFB,
                16'h0003, 1'b0);
        add_row(ACTION_STORE, 16'h0001, 16'h0005, FLAG_UPPER, 16'h2222, 8'd20, 16'h0010,
                16'hFFF0, 1'b0);
        // zero tag slot with depth: move-only, no-write, and the pv margin edge
        add_row(ACTION_STORE, 16'h0002, 16'h0000, FLAG_EXACT, 16'h0ABC, 8'd40, 16'h0100,
                16'h0200, 1'b0);
        add_row(ACTION_STORE, 16'h0002, 16'h0000, FLAG_LOWER, 16'h3333, 8'd10, 16'h0, 16'h0,
                1'b0);
        add_row(ACTION_STORE, 16'h0002, 16'h0000, FLAG_UPPER, 16'h0000, 8'd10, 16'h0, 16'h0,
                1'b1);
        add_row(ACTION_STORE, 16'h0002, 16'h0000, FLAG_LOWER, 16'h4444, 8'd27, 16'h0, 16'h0,
                1'b1);
        add_row(ACTION_STORE, 16'h0002, 16'h0000, FLAG_LOWER, 16'h5555, 8'd28, 16'h1, 16'h1,
                1'b1);
        add_row(ACTION_PROBE, 16'h0002, 16'h0000, FLAG_EXACT, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0);
        // flag value three is stored as given
        add_row(ACTION_STORE, 16'h0003, 16'h0009, FLAG_THREE, 16'h0101, 8'd5, 16'h0, 16'h0,
                1'b0);
        add_row(ACTION_PROBE, 16'h0003, 16'h0009, FLAG_EXACT, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0);
        // opposite extremes on the top slot, and an exact rewrite at full depth
        add_row(ACTION_STORE, 16'hFFFF, 16'hFFFF, FLAG_UPPER, 16'h8000, 8'h00, 16'h8000,
                16'h7FFF, 1'b0);
        add_row(ACTION_PROBE, 16'hFFFF, 16'hFFFF, FLAG_EXACT, 16'h0, 8'h00, 16'h0, 16'h0, 1'b0);
        add_row(ACTION_STORE, 16'h0000, 16'h0001, FLAG_EXACT, 16'h0001, 8'hFF, 16'h0, 16'hFFFF,
                1'b0);

        foreach (directed_rows[n])
            send_item(directed_rows[n].req, directed_rows[n].fixed, directed_rows[n].want);

        for (ph = 0; ph < AGE_PHASES; ph++) begin
            drain();
            set_age((ph == AGE_PHASES - 1) ? 8'($urandom) : phase_ages[ph]);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
                if (ph == 0 && n == ITEMS_PER_PHASE / 2) drain();
                send_item(random_request(), 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("sent %0d probes and %0d stores over %0d age settings",
                 probes_sent, stores_sent, AGE_PHASES + 1);
        $display("results: %0d hits, %0d full writes, %0d move-only, %0d without a write",
                 hits_seen, full_seen, move_seen, none_seen);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
